@@ sv/rte_pkg.sv @@
// Shared constants and types for the R-type execute block.
`default_nettype none
package rte_pkg;

  localparam logic [6:0] OP_RTYPE   = 7'h33;
  localparam logic [6:0] F7_BASE    = 7'h00;
  localparam logic [6:0] F7_ALT     = 7'h20;
  localparam logic [4:0] SHAMT_MASK = 5'h1F;
  localparam logic [31:0] PC_STEP   = 32'd4;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned REG_AW   = 5;
  localparam int unsigned REG_NUM  = 32;

  typedef logic [XLEN-1:0]   word_t;
  typedef logic [REG_AW-1:0] reg_idx_t;

  typedef enum logic [2:0] {
    F3_ADD  = 3'd0,
    F3_SLL  = 3'd1,
    F3_SLT  = 3'd2,
    F3_SLTU = 3'd3,
    F3_XOR  = 3'd4,
    F3_SR   = 3'd5,
    F3_OR   = 3'd6,
    F3_AND  = 3'd7
  } funct3_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_OPCODE = 2'd1,
    ERR_FUNCT  = 2'd2
  } err_t;

  typedef enum logic {
    KIND_EXEC  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  // Configuration register byte offsets
  localparam logic [1:0] CFG_START_PC = 2'd0;

  // ALU result bundle
  typedef struct packed {
    word_t res;
    logic  ok;
  } alu_out_t;

endpackage
`default_nettype wire

@@ sv/rte_if.sv @@
// Valid/ready channel interfaces for instruction beats and result beats.
`default_nettype none
interface rte_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [6:0]  opcode;
  logic [2:0]  funct3;
  logic [6:0]  funct7;
  logic [4:0]  dest_index;
  logic [4:0]  src1_index;
  logic [4:0]  src2_index;
  logic [31:0] load_value;

  modport source (output valid, kind, opcode, funct3, funct7, dest_index, src1_index,
                  src2_index, load_value, input ready);
  modport sink (input valid, kind, opcode, funct3, funct7, dest_index, src1_index,
                src2_index, load_value, output ready);
endinterface

interface rte_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  written_index;
  logic [31:0] written_value;
  logic        did_write;
  logic [31:0] pc_now;
  logic        halted;
  logic [1:0]  error_code;

  modport source (output valid, written_index, written_value, did_write, pc_now, halted,
                  error_code, input ready);
  modport sink (input valid, written_index, written_value, did_write, pc_now, halted,
                error_code, output ready);
endinterface
`default_nettype wire

@@ sv/rte_alu.sv @@
// R-type ALU with funct3/funct7 legality check.
`default_nettype none
module rte_alu (
  input  wire logic [2:0]      funct3,
  input  wire logic [6:0]      funct7,
  input  rte_pkg::word_t       op_a,
  input  rte_pkg::word_t       op_b,
  output rte_pkg::alu_out_t    alu_o
);

  logic       alt;
  logic [4:0] shamt;

  assign alt   = (funct7 == rte_pkg::F7_ALT);
  assign shamt = op_b[4:0] & rte_pkg::SHAMT_MASK;

  always_comb begin
    alu_o.ok  = (funct7 == rte_pkg::F7_BASE) ||
                (alt && (funct3 == rte_pkg::F3_ADD || funct3 == rte_pkg::F3_SR));
    alu_o.res = '0;
    unique case (rte_pkg::funct3_t'(funct3))
      rte_pkg::F3_ADD:  alu_o.res = alt ? op_a - op_b : op_a + op_b;
      rte_pkg::F3_SLL:  alu_o.res = op_a << shamt;
      rte_pkg::F3_SLT:  alu_o.res = {31'd0, $signed(op_a) < $signed(op_b)};
      rte_pkg::F3_SLTU: alu_o.res = {31'd0, op_a < op_b};
      rte_pkg::F3_XOR:  alu_o.res = op_a ^ op_b;
      rte_pkg::F3_SR:   alu_o.res = alt ? rte_pkg::word_t'($signed(op_a) >>> shamt)
                                        : op_a >> shamt;
      rte_pkg::F3_OR:   alu_o.res = op_a | op_b;
      rte_pkg::F3_AND:  alu_o.res = op_a & op_b;
      default:          alu_o.res = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/rv32_rtype_execute.sv @@
// Top level of the RV32I R-type execute block.
// One beat per clock cycle sustained while the output accepts results. A beat
// reads both sources from the 32x32 register file (synchronous read) into the
// read registers, then executes and commits from the execute stage into the
// result register; a result that waits at the output stalls the beat in the
// execute stage, and a full execute stage stalls the input. A source written
// by the beat committing in the read cycle is forwarded. Register x0 reads as
// zero; a register never written since reset reads as zero through per-entry
// valid bits. Writing start_pc (offset 0) reloads the program counter at once.
`default_nettype none
module rv32_rtype_execute (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rte_in_if.sink           in_ch,
  rte_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // Configuration and architectural state
  rte_pkg::word_t start_pc_r;
  rte_pkg::word_t pc_r, pc_nxt;
  logic           halt_r, halt_nxt;
  logic           cfg_we;

  // Register file
  rte_pkg::word_t                 rf_mem [rte_pkg::REG_NUM];
  logic [rte_pkg::REG_NUM-1:0]    rf_vld_r;
  rte_pkg::word_t                 rd1_r, rd2_r;

  // Execute stage
  logic               s1_valid_r;
  logic               s1_kind_r;
  logic [6:0]         s1_opcode_r;
  logic [2:0]         s1_funct3_r;
  logic [6:0]         s1_funct7_r;
  rte_pkg::reg_idx_t  s1_dest_r;
  rte_pkg::word_t     s1_load_r;
  logic               s1_sel1_r, s1_sel2_r;
  rte_pkg::word_t     s1_bp1_r, s1_bp2_r;
  rte_pkg::word_t     op_a, op_b;
  rte_pkg::alu_out_t  alu_o;

  // Commit
  logic               s1_go;
  logic               in_acc;
  logic               cm_we;
  rte_pkg::word_t     cm_val;
  rte_pkg::err_t      cm_err;

  // Output register
  logic               out_valid_r;
  rte_pkg::reg_idx_t  out_index_r;
  rte_pkg::word_t     out_value_r;
  logic               out_wr_r;
  rte_pkg::word_t     out_pc_r;
  logic               out_halt_r;
  rte_pkg::err_t      out_err_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = start_pc_r;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == rte_pkg::CFG_START_PC);

  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign op_a = s1_sel1_r ? s1_bp1_r : rd1_r;
  assign op_b = s1_sel2_r ? s1_bp2_r : rd2_r;

  rte_alu u_alu (
    .funct3 (s1_funct3_r),
    .funct7 (s1_funct7_r),
    .op_a   (op_a),
    .op_b   (op_b),
    .alu_o  (alu_o)
  );

  always_comb begin
    cm_we    = 1'b0;
    cm_val   = '0;
    cm_err   = rte_pkg::ERR_NONE;
    pc_nxt   = pc_r;
    halt_nxt = halt_r;
    if (s1_kind_r == rte_pkg::KIND_WRITE) begin
      cm_we  = (s1_dest_r != '0);
      cm_val = s1_load_r;
    end else if (!halt_r) begin
      if (s1_opcode_r != rte_pkg::OP_RTYPE) begin
        cm_err   = rte_pkg::ERR_OPCODE;
        halt_nxt = 1'b1;
      end else if (alu_o.ok) begin
        cm_we  = (s1_dest_r != '0);
        cm_val = alu_o.res;
        pc_nxt = pc_r + rte_pkg::PC_STEP;
      end else begin
        cm_err   = rte_pkg::ERR_FUNCT;
        halt_nxt = 1'b1;
      end
    end
  end

  // Register file array: write at commit, read both sources on accept
  always_ff @(posedge clk) begin
    if (s1_go && cm_we) begin
      rf_mem[s1_dest_r] <= cm_val;
    end
    if (in_acc) begin
      rd1_r <= rf_mem[in_ch.src1_index];
      rd2_r <= rf_mem[in_ch.src2_index];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (s1_go && cm_we) begin
      rf_vld_r[s1_dest_r] <= 1'b1;
    end
  end

  // Bypass select: forward the committing value, or zero for an unwritten entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r   <= in_ch.kind;
      s1_opcode_r <= in_ch.opcode;
      s1_funct3_r <= in_ch.funct3;
      s1_funct7_r <= in_ch.funct7;
      s1_dest_r   <= in_ch.dest_index;
      s1_load_r   <= in_ch.load_value;
      if (s1_go && cm_we && s1_dest_r == in_ch.src1_index) begin
        s1_sel1_r <= 1'b1;
        s1_bp1_r  <= cm_val;
      end else begin
        s1_sel1_r <= !rf_vld_r[in_ch.src1_index];
        s1_bp1_r  <= '0;
      end
      if (s1_go && cm_we && s1_dest_r == in_ch.src2_index) begin
        s1_sel2_r <= 1'b1;
        s1_bp2_r  <= cm_val;
      end else begin
        s1_sel2_r <= !rf_vld_r[in_ch.src2_index];
        s1_bp2_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      start_pc_r  <= '0;
      halt_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        start_pc_r <= cfg_pwdata;
        pc_r       <= cfg_pwdata;
      end else if (s1_go) begin
        pc_r <= pc_nxt;
      end
      if (s1_go) begin
        halt_r <= halt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_index_r <= cm_we ? s1_dest_r : '0;
      out_value_r <= cm_we ? cm_val : '0;
      out_wr_r    <= cm_we;
      out_pc_r    <= pc_nxt;
      out_halt_r  <= halt_nxt;
      out_err_r   <= cm_err;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.written_index = out_index_r;
  assign out_ch.written_value = out_value_r;
  assign out_ch.did_write     = out_wr_r;
  assign out_ch.pc_now        = out_pc_r;
  assign out_ch.halted        = out_halt_r;
  assign out_ch.error_code    = out_err_r;

endmodule
`default_nettype wire
